[sv/xmodem_crc_receiver_unit_macros.svh]
// Assertion macros shared by the XMODEM-CRC receiver RTL.
`ifndef XMODEM_CRC_RECEIVER_UNIT_MACROS_SVH
`define XMODEM_CRC_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define XCR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define XCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/xcr_pkg.sv]
// Package with types, codes and the CRC step of the XMODEM-CRC receiver.
package xcr_pkg;

    localparam int BLOCK_BYTES_DEF = 128;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] B_SOH = 8'h01;
    localparam logic [7:0] B_EOT = 8'h04;
    localparam logic [7:0] B_ACK = 8'h06;
    localparam logic [7:0] B_NAK = 8'h15;
    localparam logic [7:0] B_CAN = 8'h18;
    localparam logic [7:0] B_C   = 8'h43;

    localparam logic [3:0]  MAX_ERRORS_RST  = 4'd5;
    localparam logic [15:0] STD_TIMEOUT_RST = 16'd3000;
    localparam logic [15:0] DRAIN_TIMEOUT_RST = 16'd300;
    localparam logic [23:0] CAPACITY_RST    = 24'hFF_FFFF;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_BYTE  = 2'd1,
        MODE_TICK  = 2'd2
    } t_mode;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAX_ERRORS    = 2'd0,
        CFG_STD_TIMEOUT   = 2'd1,
        CFG_DRAIN_TIMEOUT = 2'd2,
        CFG_CAPACITY      = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LEAD  = 3'd1,
        PH_BODY  = 3'd2,
        PH_DRAIN = 3'd3,
        PH_DONE  = 3'd4,
        PH_FAIL  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        VERDICT_NONE    = 2'd0,
        VERDICT_COMMIT  = 2'd1,
        VERDICT_DISCARD = 2'd2
    } t_verdict;

    typedef enum logic [1:0] {
        STATUS_IDLE    = 2'd0,
        STATUS_RUNNING = 2'd1,
        STATUS_OK      = 2'd2,
        STATUS_FAILED  = 2'd3
    } t_status;

    // Packed so that tx_valid lands in the lowest bit.
    typedef struct packed {
        logic [23:0] received_length;
        t_status     session_status;
        t_verdict    verdict;
        logic [23:0] data_offset;
        logic [7:0]  data_byte;
        logic        data_valid;
        logic [7:0]  tx_byte;
        logic        tx_valid;
    } t_result;

    localparam int RESULT_W = $bits(t_result);
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    // CRC-16/XMODEM update by one byte, MSB first.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[sv/xmodem_crc_receiver_unit.sv]
// Top level of the XMODEM-CRC receiver: session control, CRC and reply generation.
//
//   Channel  Direction  Payload
//   s_axis   in         tuser: mode; tdata: rx_byte
//   m_axis   out        tdata: tx/data/verdict/status/length result
//   i_cfg_*  in         register index and write data
//
// Every beat is handled combinationally: the whole state update and the result
// are computed from the incoming beat and the session registers.
// One result beat per input beat; a new beat is taken every cycle unless the skid register is full.
// A two-entry output (result register plus skid register) keeps the input
// open for one beat while the output stalls; s_axis_tready is registered.
// Reset is synchronous and active low; it clears the session and output valid flags and loads config defaults.
`include "xmodem_crc_receiver_unit_macros.svh"

module xmodem_crc_receiver_unit
    import xcr_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,  // [7:0] rx_byte
    input  logic [1:0]             s_axis_tuser,  // [1:0] mode
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] data_valid, [17:10] data_byte,
    // [41:18] data_offset, [43:42] verdict, [45:44] session_status,
    // [69:46] received_length, upper bits zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = $clog2(BLOCK_BYTES + 4);
    localparam logic [IDX_W-1:0] POS_SEQ   = IDX_W'(0);
    localparam logic [IDX_W-1:0] POS_COMP  = IDX_W'(1);
    localparam logic [IDX_W-1:0] POS_DATA  = IDX_W'(2);
    localparam logic [IDX_W-1:0] POS_CRCHI = IDX_W'(BLOCK_BYTES + 2);
    localparam logic [24:0] BLOCK_LEN = 25'(BLOCK_BYTES);

    // Configuration registers.
    logic [3:0]  r_max_errors;
    logic [15:0] r_std_timeout;
    logic [15:0] r_drain_timeout;
    logic [23:0] r_capacity;

    // Session state.
    t_phase           r_phase, n_phase;
    logic [7:0]       r_expected, n_expected;
    logic [7:0]       r_seq_byte, n_seq_byte;
    logic [7:0]       r_seq_comp, n_seq_comp;
    logic [IDX_W-1:0] r_index, n_index;
    logic [15:0]      r_crc, n_crc;
    logic [15:0]      r_rx_crc, n_rx_crc;
    logic [3:0]       r_error_count, n_error_count;
    logic             r_started, n_started;
    logic [23:0]      r_committed, n_committed;
    logic [15:0]      r_silence, n_silence;

    // Output stage.
    t_result r_out, r_skid, n_res;
    logic    r_out_valid, r_skid_valid;

    logic        w_accept, w_take;
    t_mode       w_mode;
    logic [7:0]  w_byte;
    logic [3:0]  w_err_inc;
    t_phase      w_fail_phase;
    logic [7:0]  w_nak;
    logic [15:0] w_sil_inc;
    logic [15:0] w_limit;
    logic [15:0] w_full_crc;
    logic [24:0] w_fill;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_take   = m_axis_tvalid && m_axis_tready;
    assign w_mode   = t_mode'(s_axis_tuser);
    assign w_byte   = s_axis_tdata;

    assign w_err_inc    = (r_error_count != 4'hF) ? r_error_count + 4'd1 : r_error_count;
    assign w_fail_phase = (w_err_inc >= r_max_errors) ? PH_FAIL : PH_LEAD;
    assign w_nak        = r_started ? B_NAK : B_C;
    assign w_sil_inc    = (r_silence != 16'hFFFF) ? r_silence + 16'd1 : r_silence;
    assign w_limit      = (r_phase == PH_DRAIN) ? r_drain_timeout : r_std_timeout;
    assign w_full_crc   = {r_rx_crc[15:8], w_byte};
    assign w_fill       = {1'b0, r_committed} + BLOCK_LEN;

    always_comb begin
        n_phase       = r_phase;
        n_expected    = r_expected;
        n_seq_byte    = r_seq_byte;
        n_seq_comp    = r_seq_comp;
        n_index       = r_index;
        n_crc         = r_crc;
        n_rx_crc      = r_rx_crc;
        n_error_count = r_error_count;
        n_started     = r_started;
        n_committed   = r_committed;
        n_silence     = r_silence;
        n_res         = '0;

        case (w_mode)
            MODE_START: begin
                n_phase       = PH_LEAD;
                n_expected    = 8'd1;
                n_seq_byte    = '0;
                n_seq_comp    = '0;
                n_index       = '0;
                n_crc         = '0;
                n_rx_crc      = '0;
                n_error_count = '0;
                n_started     = 1'b0;
                n_committed   = '0;
                n_silence     = '0;
                n_res.tx_valid = 1'b1;
                n_res.tx_byte  = B_C;
            end
            MODE_BYTE: begin
                case (r_phase)
                    PH_LEAD: begin
                        n_silence = '0;
                        if (w_byte == B_SOH) begin
                            n_phase = PH_BODY;
                            n_index = '0;
                            n_crc   = '0;
                        end else if (w_byte == B_EOT) begin
                            n_phase = PH_DONE;
                            n_res.tx_valid = 1'b1;
                            n_res.tx_byte  = B_ACK;
                        end else begin
                            n_phase = PH_DRAIN;
                        end
                    end
                    PH_DRAIN: begin
                        n_silence = '0;
                    end
                    PH_BODY: begin
                        n_silence = '0;
                        n_index   = r_index + IDX_W'(1);
                        if (r_index == POS_SEQ) begin
                            n_seq_byte = w_byte;
                        end else if (r_index == POS_COMP) begin
                            n_seq_comp = w_byte;
                        end else if (r_index < POS_CRCHI) begin
                            n_crc = crc_step(r_crc, w_byte);
                            n_res.data_valid  = 1'b1;
                            n_res.data_byte   = w_byte;
                            n_res.data_offset = r_committed + 24'(r_index - POS_DATA);
                        end else if (r_index == POS_CRCHI) begin
                            n_rx_crc = {w_byte, 8'h00};
                        end else begin
                            n_rx_crc = w_full_crc;
                            n_res.tx_valid = 1'b1;
                            if (r_seq_byte != ~r_seq_comp || w_full_crc != r_crc) begin
                                n_res.verdict = VERDICT_DISCARD;
                                n_res.tx_byte = w_nak;
                                n_error_count = w_err_inc;
                                n_phase       = w_fail_phase;
                            end else if (r_seq_byte == r_expected - 8'd1) begin
                                n_res.verdict = VERDICT_DISCARD;
                                n_res.tx_byte = B_ACK;
                                n_phase       = PH_LEAD;
                            end else if (r_seq_byte != r_expected
                                         || w_fill > {1'b0, r_capacity}) begin
                                n_res.verdict = VERDICT_DISCARD;
                                n_res.tx_byte = B_CAN;
                                n_phase       = PH_FAIL;
                            end else begin
                                n_res.verdict = VERDICT_COMMIT;
                                n_res.tx_byte = B_ACK;
                                n_committed   = w_fill[23:0];
                                n_expected    = r_expected + 8'd1;
                                n_error_count = '0;
                                n_started     = 1'b1;
                                n_phase       = PH_LEAD;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            MODE_TICK: begin
                if (r_phase == PH_LEAD || r_phase == PH_BODY || r_phase == PH_DRAIN) begin
                    n_silence = w_sil_inc;
                    if (w_sil_inc >= w_limit) begin
                        if (r_phase == PH_BODY) begin
                            n_res.verdict = VERDICT_DISCARD;
                        end
                        n_res.tx_valid = 1'b1;
                        n_res.tx_byte  = w_nak;
                        n_error_count  = w_err_inc;
                        n_phase        = w_fail_phase;
                        n_silence      = '0;
                    end
                end
            end
            default: begin
            end
        endcase

        case (n_phase)
            PH_IDLE: n_res.session_status = STATUS_IDLE;
            PH_DONE: n_res.session_status = STATUS_OK;
            PH_FAIL: n_res.session_status = STATUS_FAILED;
            default: n_res.session_status = STATUS_RUNNING;
        endcase
        n_res.received_length = n_committed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_errors    <= MAX_ERRORS_RST;
            r_std_timeout   <= STD_TIMEOUT_RST;
            r_drain_timeout <= DRAIN_TIMEOUT_RST;
            r_capacity      <= CAPACITY_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MAX_ERRORS:    r_max_errors    <= i_cfg_data[3:0];
                CFG_STD_TIMEOUT:   r_std_timeout   <= i_cfg_data[15:0];
                CFG_DRAIN_TIMEOUT: r_drain_timeout <= i_cfg_data[15:0];
                CFG_CAPACITY:      r_capacity      <= i_cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_expected    <= 8'd1;
            r_seq_byte    <= '0;
            r_seq_comp    <= '0;
            r_index       <= '0;
            r_crc         <= '0;
            r_rx_crc      <= '0;
            r_error_count <= '0;
            r_started     <= 1'b0;
            r_committed   <= '0;
            r_silence     <= '0;
        end else if (w_accept) begin
            r_phase       <= n_phase;
            r_expected    <= n_expected;
            r_seq_byte    <= n_seq_byte;
            r_seq_comp    <= n_seq_comp;
            r_index       <= n_index;
            r_crc         <= n_crc;
            r_rx_crc      <= n_rx_crc;
            r_error_count <= n_error_count;
            r_started     <= n_started;
            r_committed   <= n_committed;
            r_silence     <= n_silence;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_accept) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_accept) begin
            if (!r_out_valid || w_take) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign s_axis_tready = !r_skid_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out);

    `XCR_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid beat without result beat")
    `XCR_ASSERT_NOW(a_data_no_reply, i_clk, i_rst_n, r_out_valid && r_out.data_valid, !r_out.tx_valid && r_out.verdict == VERDICT_NONE, "payload beat carries a reply")
    `XCR_ASSERT_NOW(a_commit_acks, i_clk, i_rst_n, r_out_valid && r_out.verdict == VERDICT_COMMIT, r_out.tx_valid && r_out.tx_byte == B_ACK, "commit without ACK")
    `XCR_ASSERT_NEXT(a_body_holds_session, i_clk, i_rst_n, w_accept && r_phase == PH_BODY && w_mode == MODE_BYTE && r_index < POS_CRCHI, r_phase == PH_BODY, "packet left before its CRC")

endmodule
